// ===== rtl/estm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_pkg
// Shared types, constants and arithmetic helpers for the Euler-angle model and
// normal matrix block.
// ----------------------------------------------------------------------------
package estm_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [31:0] ATAN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic       KIND_MODEL  = 1'b0;
    localparam logic       KIND_NORMAL = 1'b1;
    localparam logic [2:0] COL_TRANS   = 3'd3;
    localparam logic [2:0] COL_NORMAL0 = 3'd4;
    localparam logic [2:0] COL_LAST    = 3'd6;
    localparam logic [1:0] IDX_TRANS   = 2'd3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_cord;

    // One rotation-mode step; steps past the end hold the vector.
    function automatic t_cord cord_step(t_cord c, int i);
        t_cord r;
        r = c;
        if (i < CORDIC_STEPS) begin
            if (!c.z[32]) begin
                r.x = $signed(c.x) - ($signed(c.y) >>> i);
                r.y = $signed(c.y) + ($signed(c.x) >>> i);
                r.z = $signed(c.z) - $signed({1'b0, ATAN[i]});
            end else begin
                r.x = $signed(c.x) + ($signed(c.y) >>> i);
                r.y = $signed(c.y) - ($signed(c.x) >>> i);
                r.z = $signed(c.z) + $signed({1'b0, ATAN[i]});
            end
        end
        return r;
    endfunction

    // Q30 product, rounded half up.
    function automatic logic signed [32:0] mul30(logic signed [31:0] a,
                                                 logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        return 33'(p >>> 30);
    endfunction

endpackage

// ===== rtl/euler_scale_transform_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_scale_transform_matrix
// Model and normal matrix columns from Y-X-Z Euler angles, scale and
// translation, in fixed point.
// ----------------------------------------------------------------------------
// Each item yields seven columns on the result channel, one per cycle through
// the output register while i_stall is low. New items enter the front pipeline
// while earlier ones are still being sent, until its last stage fills. The front
// pipeline runs three sine/cosine CORDIC lanes and three reciprocal dividers two
// steps per stage (17 stages at FRAC_BITS = 16), then four product stages.
module euler_scale_transform_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic        [15:0] i_rot_x,
    input  logic        [15:0] i_rot_y,
    input  logic        [15:0] i_rot_z,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    input  logic signed [31:0] i_scale_z,
    input  logic signed [31:0] i_trans_x,
    input  logic signed [31:0] i_trans_y,
    input  logic signed [31:0] i_trans_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_matrix_kind,
    output logic        [1:0]  o_column_index,
    output logic signed [31:0] o_elem_0,
    output logic signed [31:0] o_elem_1,
    output logic signed [31:0] o_elem_2,
    output logic               o_saturated,
    output logic               o_last_column
);

    localparam int NW  = (2 * FRAC_BITS > 32 ? 2 * FRAC_BITS : 32) + 1;
    localparam int LC  = (estm_pkg::CORDIC_STEPS + 1) / 2;
    localparam int LD  = (NW + 1) / 2;
    localparam int L   = LC > LD ? LC : LD;
    localparam int D   = L + 5;
    localparam logic [NW-1:0] ONE_SQ    = NW'(1) << (2 * FRAC_BITS);
    localparam logic [NW-1:0] Q_POS_MAX = NW'(33'h0_7FFF_FFFF);
    localparam logic [NW-1:0] Q_NEG_MAX = NW'(33'h0_8000_0000);
    localparam logic signed [65:0] HALF = 66'sd536870912;

    typedef struct packed {
        logic [31:0]   rem;
        logic [NW-1:0] num;
        logic [NW-1:0] q;
    } t_div;

    function automatic t_div div_step(t_div d, logic [31:0] mag, int i);
        t_div        r;
        logic [32:0] t;
        r = d;
        t = {d.rem, d.num[NW-1]};
        if (i < NW) begin
            r.num = d.num << 1;
            if (t >= {1'b0, mag}) begin
                r.rem = 32'(t - {1'b0, mag});
                r.q   = {d.q[NW-2:0], 1'b1};
            end else begin
                r.rem = t[31:0];
                r.q   = {d.q[NW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic                  en;
    logic [D-1:0]          r_v;
    estm_pkg::t_cord       r_cd   [0:L][3];
    logic [1:0]            r_quad [0:L][3];
    t_div                  r_dv   [0:L][3];
    logic [31:0]           r_mag  [0:L][3];
    logic                  r_neg  [0:L][3];
    logic                  r_zero [0:L][3];
    logic signed [31:0]    r_scl  [0:D-1][3];
    logic signed [31:0]    r_trn  [0:D-1][3];

    logic [15:0]           w_ang  [3];
    logic signed [31:0]    w_scl  [3];
    logic signed [31:0]    w_trn  [3];
    logic [31:0]           w_ph   [3];
    logic [31:0]           w_mag  [3];

    // P0..P3 stages
    logic signed [31:0]    r_c    [3];
    logic signed [31:0]    r_s    [3];
    logic signed [31:0]    r_rcp  [4][3];
    logic                  r_rsat [4][3];
    logic signed [31:0]    r1_c   [3];
    logic signed [31:0]    r1_s   [3];
    logic signed [32:0]    r1_s1s2;
    logic signed [32:0]    r1_c1s2;
    logic signed [32:0]    r2_m   [12];
    logic signed [31:0]    r2_s2;
    logic signed [33:0]    r_rot  [3][3];
    logic signed [31:0]    n_c    [3];
    logic signed [31:0]    n_s    [3];
    logic signed [31:0]    n_rcp  [3];
    logic                  n_rsat [3];

    // Column sequencer and output register
    logic                  r_s_v;
    logic [2:0]            r_col;
    logic signed [33:0]    r_s_rot  [3][3];
    logic signed [31:0]    r_s_scl  [3];
    logic signed [31:0]    r_s_rcp  [3];
    logic                  r_s_rsat [3];
    logic signed [31:0]    r_s_trn  [3];
    logic                  r_o_v;
    logic                  o_free;
    logic                  ser_load;
    logic                  n_kind;
    logic [1:0]            n_idx;
    logic signed [31:0]    n_fac;
    logic signed [31:0]    n_e      [3];
    logic                  n_sat;
    logic signed [65:0]    n_p      [3];
    logic signed [35:0]    n_r      [3];

    assign w_ang = '{i_rot_y, i_rot_x, i_rot_z};
    assign w_scl = '{i_scale_x, i_scale_y, i_scale_z};
    assign w_trn = '{i_trans_x, i_trans_y, i_trans_z};

    assign o_free   = !r_o_v || !i_stall;
    assign ser_load = !r_s_v || (o_free && r_col == estm_pkg::COL_LAST);
    assign en       = !(r_v[D-1] && !ser_load);
    assign o_stall  = !en;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_ph[a]  = 32'({16'b0, w_ang[a]} << (32 - ANGLE_BITS));
            w_mag[a] = w_scl[a][31] ? 32'(-w_scl[a]) : 32'(w_scl[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[D-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_cd[0][a].x   <= estm_pkg::CORDIC_GAIN;
                r_cd[0][a].y   <= '0;
                r_cd[0][a].z   <= {3'b000, w_ph[a][29:0]};
                r_quad[0][a]   <= w_ph[a][31:30];
                r_dv[0][a].rem <= '0;
                r_dv[0][a].num <= ONE_SQ + NW'(w_mag[a][31:1]);
                r_dv[0][a].q   <= '0;
                r_mag[0][a]    <= w_mag[a];
                r_neg[0][a]    <= w_scl[a][31];
                r_zero[0][a]   <= w_scl[a] == 32'sd0;
                r_scl[0][a]    <= w_scl[a];
                r_trn[0][a]    <= w_trn[a];
            end
        end
    end

    for (genvar gs = 1; gs <= L; gs++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int a = 0; a < 3; a++) begin
                    r_cd[gs][a] <= estm_pkg::cord_step(
                        estm_pkg::cord_step(r_cd[gs-1][a], 2 * gs - 2), 2 * gs - 1);
                    r_dv[gs][a] <= div_step(
                        div_step(r_dv[gs-1][a], r_mag[gs-1][a], 2 * gs - 2),
                        r_mag[gs-1][a], 2 * gs - 1);
                    r_quad[gs][a] <= r_quad[gs-1][a];
                    r_mag[gs][a]  <= r_mag[gs-1][a];
                    r_neg[gs][a]  <= r_neg[gs-1][a];
                    r_zero[gs][a] <= r_zero[gs-1][a];
                end
            end
        end
    end

    for (genvar gp = 1; gp < D; gp++) begin : g_pass
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_scl[gp] <= r_scl[gp-1];
                r_trn[gp] <= r_trn[gp-1];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            case (r_quad[L][a])
                estm_pkg::QUAD_0: begin
                    n_c[a] = 32'(r_cd[L][a].x);
                    n_s[a] = 32'(r_cd[L][a].y);
                end
                estm_pkg::QUAD_1: begin
                    n_c[a] = 32'(-r_cd[L][a].y);
                    n_s[a] = 32'(r_cd[L][a].x);
                end
                estm_pkg::QUAD_2: begin
                    n_c[a] = 32'(-r_cd[L][a].x);
                    n_s[a] = 32'(-r_cd[L][a].y);
                end
                default: begin
                    n_c[a] = 32'(r_cd[L][a].y);
                    n_s[a] = 32'(-r_cd[L][a].x);
                end
            endcase
            if (r_zero[L][a]) begin
                n_rcp[a]  = estm_pkg::S32_MAX;
                n_rsat[a] = 1'b1;
            end else if (!r_neg[L][a]) begin
                n_rsat[a] = r_dv[L][a].q > Q_POS_MAX;
                n_rcp[a]  = n_rsat[a] ? estm_pkg::S32_MAX : 32'(r_dv[L][a].q);
            end else begin
                n_rsat[a] = r_dv[L][a].q > Q_NEG_MAX;
                n_rcp[a]  = n_rsat[a] ? estm_pkg::S32_MIN : 32'(NW'(0) - r_dv[L][a].q);
            end
        end
    end

    // c[0]/s[0] yaw, c[1]/s[1] pitch, c[2]/s[2] roll
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c         <= n_c;
            r_s         <= n_s;
            r_rcp[0]    <= n_rcp;
            r_rsat[0]   <= n_rsat;
            for (int k = 1; k < 4; k++) begin
                r_rcp[k]  <= r_rcp[k-1];
                r_rsat[k] <= r_rsat[k-1];
            end
            r1_c        <= r_c;
            r1_s        <= r_s;
            r1_s1s2     <= estm_pkg::mul30(r_s[0], r_s[1]);
            r1_c1s2     <= estm_pkg::mul30(r_c[0], r_s[1]);
            r2_m[0]     <= estm_pkg::mul30(r1_c[0], r1_c[2]);
            r2_m[1]     <= estm_pkg::mul30(32'(r1_s1s2), r1_s[2]);
            r2_m[2]     <= estm_pkg::mul30(r1_c[1], r1_s[2]);
            r2_m[3]     <= estm_pkg::mul30(32'(r1_c1s2), r1_s[2]);
            r2_m[4]     <= estm_pkg::mul30(r1_c[2], r1_s[0]);
            r2_m[5]     <= estm_pkg::mul30(32'(r1_s1s2), r1_c[2]);
            r2_m[6]     <= estm_pkg::mul30(r1_c[0], r1_s[2]);
            r2_m[7]     <= estm_pkg::mul30(r1_c[1], r1_c[2]);
            r2_m[8]     <= estm_pkg::mul30(32'(r1_c1s2), r1_c[2]);
            r2_m[9]     <= estm_pkg::mul30(r1_s[0], r1_s[2]);
            r2_m[10]    <= estm_pkg::mul30(r1_c[1], r1_s[0]);
            r2_m[11]    <= estm_pkg::mul30(r1_c[0], r1_c[1]);
            r2_s2       <= r1_s[1];
            r_rot[0][0] <= 34'(r2_m[0]) + 34'(r2_m[1]);
            r_rot[0][1] <= 34'(r2_m[2]);
            r_rot[0][2] <= 34'(r2_m[3]) - 34'(r2_m[4]);
            r_rot[1][0] <= 34'(r2_m[5]) - 34'(r2_m[6]);
            r_rot[1][1] <= 34'(r2_m[7]);
            r_rot[1][2] <= 34'(r2_m[8]) + 34'(r2_m[9]);
            r_rot[2][0] <= 34'(r2_m[10]);
            r_rot[2][1] <= -34'(r2_s2);
            r_rot[2][2] <= 34'(r2_m[11]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
            r_col <= '0;
            r_o_v <= 1'b0;
        end else begin
            if (o_free) begin
                r_o_v <= r_s_v;
            end
            if (ser_load) begin
                r_s_v <= r_v[D-1];
                r_col <= '0;
            end else if (o_free) begin
                r_col <= r_col + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_s_rot  <= r_rot;
            r_s_scl  <= r_scl[D-1];
            r_s_trn  <= r_trn[D-1];
            r_s_rcp  <= r_rcp[3];
            r_s_rsat <= r_rsat[3];
        end
    end

    always_comb begin
        n_kind = r_col >= estm_pkg::COL_NORMAL0;
        n_idx  = n_kind ? 2'(r_col - estm_pkg::COL_NORMAL0) : r_col[1:0];
        n_fac  = 32'sd0;
        n_sat  = 1'b0;
        if (n_kind == estm_pkg::KIND_NORMAL) begin
            n_fac = r_s_rcp[n_idx];
            n_sat = r_s_rsat[n_idx];
        end else if (n_idx != estm_pkg::IDX_TRANS) begin
            n_fac = r_s_scl[n_idx];
        end
        for (int i = 0; i < 3; i++) begin
            n_p[i] = n_fac * r_s_rot[(n_idx == estm_pkg::IDX_TRANS) ? 2'd0 : n_idx][i];
            n_r[i] = 36'((n_p[i] + HALF) >>> 30);
            if (n_r[i] > 36'(estm_pkg::S32_MAX)) begin
                n_e[i] = estm_pkg::S32_MAX;
                n_sat  = 1'b1;
            end else if (n_r[i] < 36'(estm_pkg::S32_MIN)) begin
                n_e[i] = estm_pkg::S32_MIN;
                n_sat  = 1'b1;
            end else begin
                n_e[i] = 32'(n_r[i]);
            end
        end
        if (r_col == estm_pkg::COL_TRANS) begin
            n_e   = r_s_trn;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && r_s_v) begin
            o_matrix_kind  <= n_kind;
            o_column_index <= n_idx;
            o_elem_0       <= n_e[0];
            o_elem_1       <= n_e[1];
            o_elem_2       <= n_e[2];
            o_saturated    <= n_sat;
            o_last_column  <= r_col == estm_pkg::COL_LAST;
        end
    end

    assign o_valid = r_o_v;

endmodule

// ===== rtl/estm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estm_checker
// Port-level checks on the result column sequence.
// ----------------------------------------------------------------------------
module estm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_matrix_kind,
    input logic        [1:0]  o_column_index,
    input logic signed [31:0] o_elem_0,
    input logic               o_saturated,
    input logic               o_last_column
);

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_elem_0))
        else $error("stalled item changed");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_column |-> o_matrix_kind == estm_pkg::KIND_NORMAL
        && o_column_index == 2'd2)
        else $error("last flag on wrong column");

    a_trans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_matrix_kind == estm_pkg::KIND_MODEL
        && o_column_index == estm_pkg::IDX_TRANS |-> !o_saturated)
        else $error("translation column saturated");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_matrix_kind == estm_pkg::KIND_MODEL
        && o_column_index == estm_pkg::IDX_TRANS
        |=> o_valid && o_matrix_kind == estm_pkg::KIND_NORMAL && o_column_index == 2'd0)
        else $error("normal columns do not follow translation");

endmodule

bind euler_scale_transform_matrix estm_checker u_estm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_matrix_kind  (o_matrix_kind),
    .o_column_index (o_column_index),
    .o_elem_0       (o_elem_0),
    .o_saturated    (o_saturated),
    .o_last_column  (o_last_column)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for euler_scale_transform_matrix: a directed table of
// angle, scale and translation items, then random items, each checked column
// by column against a fixed-point model of the rotation, scale and reciprocal.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM     = 450;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct {
        logic [15:0]        rx, ry, rz;
        logic signed [31:0] sx, sy, sz, tx, ty, tz;
    } t_item;

    typedef struct {
        logic               kind;
        logic [1:0]         col;
        logic signed [31:0] e0, e1, e2;
        logic               sat, last;
    } t_column;

    logic               i_clk, i_rst_n, i_valid, i_stall;
    logic [15:0]        i_rot_x, i_rot_y, i_rot_z;
    logic signed [31:0] i_scale_x, i_scale_y, i_scale_z;
    logic signed [31:0] i_trans_x, i_trans_y, i_trans_z;
    logic               o_stall, o_valid, o_matrix_kind, o_saturated, o_last_column;
    logic [1:0]         o_column_index;
    logic signed [31:0] o_elem_0, o_elem_1, o_elem_2;

    t_column      pending_columns[$];
    int           mismatches = 0;
    int           columns_seen = 0;
    int           cycle_count = 0;
    bit           quiet_phase = 0;
    bit           long_hold = 0;

    euler_scale_transform_matrix DUT (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_shift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint sat32(longint v, ref bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    task automatic angle_sincos(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] phase;
        longint      x, y, z, xn;
        phase = {ang, 16'h0};
        z = longint'(phase[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                xn = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z  = z - longint'(estm_pkg::ATAN[i]);
            end else begin
                xn = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z  = z + longint'(estm_pkg::ATAN[i]);
            end
            x = xn;
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint inverse_scale(longint sc, ref bit flag);
        longint mag, q;
        if (sc == 0) begin
            flag = 1;
            return 64'sd2147483647;
        end
        mag = sc < 0 ? -sc : sc;
        q = ((64'sd1 <<< 32) + mag / 2) / mag;
        if (sc < 0) q = -q;
        return sat32(q, flag);
    endfunction

    task automatic predict_columns(input t_item it);
        longint  c1, s1, c2, s2, c3, s3, s1s2, c1s2, inv;
        longint  rot[3][3];
        longint  sc[3];
        longint  e[3];
        bit      flag;
        t_column col;
        angle_sincos(it.ry, c1, s1);
        angle_sincos(it.rx, c2, s2);
        angle_sincos(it.rz, c3, s3);
        s1s2 = q30_mul(s1, s2);
        c1s2 = q30_mul(c1, s2);
        rot[0][0] = q30_mul(c1, c3) + q30_mul(s1s2, s3);
        rot[0][1] = q30_mul(c2, s3);
        rot[0][2] = q30_mul(c1s2, s3) - q30_mul(c3, s1);
        rot[1][0] = q30_mul(s1s2, c3) - q30_mul(c1, s3);
        rot[1][1] = q30_mul(c2, c3);
        rot[1][2] = q30_mul(c1s2, c3) + q30_mul(s1, s3);
        rot[2][0] = q30_mul(c2, s1);
        rot[2][1] = -s2;
        rot[2][2] = q30_mul(c1, c2);
        sc[0] = it.sx;
        sc[1] = it.sy;
        sc[2] = it.sz;
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 3; j++) begin
                flag = 0;
                inv = (k == 0) ? sc[j] : inverse_scale(sc[j], flag);
                for (int i = 0; i < 3; i++)
                    e[i] = sat32(floor_shift(inv * rot[j][i] + (64'sd1 <<< 29), 30), flag);
                col.kind = (k == 0) ? estm_pkg::KIND_MODEL : estm_pkg::KIND_NORMAL;
                col.col  = j[1:0];
                col.e0 = e[0][31:0];
                col.e1 = e[1][31:0];
                col.e2 = e[2][31:0];
                col.sat = flag;
                col.last = (k == 1) && (j == 2);
                pending_columns.push_back(col);
            end
            if (k == 0) begin
                col.kind = estm_pkg::KIND_MODEL;
                col.col  = estm_pkg::IDX_TRANS;
                col.e0 = it.tx;
                col.e1 = it.ty;
                col.e2 = it.tz;
                col.sat = 0;
                col.last = 0;
                pending_columns.push_back(col);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d on %s: got %0h, want %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // receiver side
    initial begin
        int hold;
        int long_cnt;
        i_stall <= 1'b0;
        hold = 0;
        long_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                long_cnt++;
                if (long_cnt >= LONG_HOLD_CYCLES) begin
                    long_hold = 0;
                    long_cnt  = 0;
                end
            end else if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_column want;
        if (i_rst_n && o_valid && !i_stall) begin
            columns_seen++;
            if (pending_columns.size() == 0) begin
                report_mismatch("unexpected column", o_column_index, 0);
            end else begin
                want = pending_columns.pop_front();
                if (o_matrix_kind !== want.kind) report_mismatch("kind", o_matrix_kind, want.kind);
                if (o_column_index !== want.col) report_mismatch("column", o_column_index, want.col);
                if (o_elem_0 !== want.e0) report_mismatch("elem_0", o_elem_0, want.e0);
                if (o_elem_1 !== want.e1) report_mismatch("elem_1", o_elem_1, want.e1);
                if (o_elem_2 !== want.e2) report_mismatch("elem_2", o_elem_2, want.e2);
                if (o_saturated !== want.sat) report_mismatch("saturated", o_saturated, want.sat);
                if (o_last_column !== want.last) report_mismatch("last", o_last_column, want.last);
            end
        end
    end

    task automatic offer_item(input t_item it, input bit allow_gap);
        int gap;
        if (allow_gap && !quiet_phase && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rot_x   <= it.rx;
        i_rot_y   <= it.ry;
        i_rot_z   <= it.rz;
        i_scale_x <= it.sx;
        i_scale_y <= it.sy;
        i_scale_z <= it.sz;
        i_trans_x <= it.tx;
        i_trans_y <= it.ty;
        i_trans_z <= it.tz;
        do @(posedge i_clk); while (o_stall);
        predict_columns(it);
    endtask

    function automatic logic signed [31:0] random_scale();
        case ($urandom_range(0, 7))
            0: return 32'sd0;
            1: return $urandom_range(1, 3);
            2: return -$signed($urandom_range(1, 3));
            3: return $urandom;
            4: return estm_pkg::S32_MAX;
            5: return estm_pkg::S32_MIN;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.rx = $urandom;
        it.ry = $urandom;
        it.rz = $urandom;
        it.sx = random_scale();
        it.sy = random_scale();
        it.sz = random_scale();
        it.tx = $urandom;
        it.ty = $urandom;
        it.tz = $urandom;
        return it;
    endfunction

    initial begin
        t_item directed[$];
        t_item it;
        t_column want;
        int    n;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        {i_rot_x, i_rot_y, i_rot_z} <= '0;
        {i_scale_x, i_scale_y, i_scale_z, i_trans_x, i_trans_y, i_trans_z} <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // angle extremes, quadrant edges, zero, tiny and huge scales
        directed.push_back('{16'h0000, 16'h0000, 16'h0000, 32'sh10000, 32'sh10000,
                             32'sh10000, 32'sh0, 32'sh0, 32'sh0});
        directed.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, estm_pkg::S32_MAX,
                             estm_pkg::S32_MIN, 32'sh10000,
                             estm_pkg::S32_MAX, estm_pkg::S32_MIN, 32'sh7});
        directed.push_back('{16'h4000, 16'h8000, 16'hC000, 32'sh0, 32'sh0, 32'sh0,
                             32'sh1234, -32'sh1, 32'sh0});
        directed.push_back('{16'h2000, 16'h6000, 16'hA000, 32'sh1, -32'sh1, 32'sh2,
                             32'sh0, 32'sh0, 32'sh0});
        directed.push_back('{16'hE000, 16'h1000, 16'h3000, -32'sh10000, 32'sh8000,
                             -32'sh20000, 32'sh55555555, 32'shAAAAAAAA, 32'sh1});
        directed.push_back('{16'h0001, 16'h7FFF, 16'h8001, estm_pkg::S32_MIN,
                             estm_pkg::S32_MAX, -32'sh3,
                             32'sh0, 32'sh0, 32'sh0});
        for (int k = 0; k < directed.size(); k++) begin
            offer_item(directed[k], 0);
        end
        // identity row must give the first unit column at a glance
        want = pending_columns[0];
        if (want.e0 !== 32'sh10000 || want.e1 !== 32'sh0 || want.e2 !== 32'sh0)
            report_mismatch("identity predictor", want.e0, 32'sh10000);
        i_valid <= 1'b0;

        for (n = 0; n < N_RANDOM; n++) begin
            if (n == 150) begin
                // sender pauses until everything has drained
                i_valid <= 1'b0;
                while (pending_columns.size() != 0) @(posedge i_clk);
            end
            if (n == 200) long_hold = 1;
            if (n == 380) quiet_phase = 1;
            it = random_item();
            offer_item(it, 1);
        end
        i_valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d columns checked, incl. zero and extreme scales",
                 N_RANDOM + directed.size(), columns_seen);
        if (mismatches == 0 && pending_columns.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
